// File: design/mf8_pkg.sv
// Package for the minifloat adder: field widths, constants and the stage payload types.
// No dependencies.
`timescale 1ns / 1ps
package mf8_pkg;
   localparam int MagWidth = 19;   // (8+7) << 15 = 491520 needs 19 bits
   localparam int SumWidth = 20;   // magnitude sum, one bit of growth over 19
   localparam logic [3:0] ExpMax = 4'hF;

   // Decoded operand pair.
   typedef struct packed {
      logic                a_sign;
      logic [MagWidth-1:0] a_mag;
      logic                b_sign;
      logic [MagWidth-1:0] b_mag;
      logic                last;
   } dec_type;

   // Signed-magnitude sum.
   typedef struct packed {
      logic                sign;
      logic [SumWidth-1:0] mag;
      logic                last;
   } add_type;

   // Leading-one position found.
   typedef struct packed {
      logic                sign;
      logic [SumWidth-1:0] mag;
      logic [4:0]          pos;
      logic                last;
   } lzd_type;
endpackage

// File: design/minifloat8_e4m3_adder.sv
// Top level of the minifloat adder: a four-stage pipeline with a skid-free stall.
// Depends on mf8_pkg.
`timescale 1ns / 1ps
// Usage: the req_ channel carries one operand pair per transaction; the rsp_
// channel returns the encoded sum of that pair with its tlast copied over.
// A pair accepted on req_ passes through the four register stages (decode, add,
// leading-one search, encode) before it is offered on rsp_. Throughput is one
// transaction per cycle while rsp_tready stays high; each stage takes a new item
// every cycle unless the stage after it is full and held.
// When rsp_tready is low and the output stage holds a result, every full stage
// up to the first empty one holds; req_tready drops only when all four stages
// are full, so nothing is lost or repeated. Stages ahead of a bubble still
// advance while stalled.
// Reset clears all valid bits; the payload registers are not reset.
module minifloat8_e4m3_adder
   import mf8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // a_code [7:0], b_code [15:8]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // sum_code [7:0]
   output logic        rsp_tlast
);
   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   logic    v1_in, v2_in, v3_in, v4_in;
   logic    en1, en2, en3, en4;
   dec_type s1_ff, s1_in;
   add_type s2_ff, s2_in;
   lzd_type s3_ff, s3_in;
   logic [7:0] s4_ff, s4_in;
   logic       l4_ff;

   // Stage enables: a stage loads when the stage after it will have room.
   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   assign v1_in = en1 ? req_tvalid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   // Decode both codes into magnitudes in units of 2^-10.
   always_comb begin
      logic [3:0] ea, eb;
      ea = req_tdata[6:3];
      eb = req_tdata[14:11];
      s1_in.a_sign = req_tdata[7];
      s1_in.b_sign = req_tdata[15];
      s1_in.a_mag  = (req_tdata[6:0] == 7'd0) ? 19'd0 : ({16'd1, req_tdata[2:0]} << ea);
      s1_in.b_mag  = (req_tdata[14:8] == 7'd0) ? 19'd0 : ({16'd1, req_tdata[10:8]} << eb);
      s1_in.last   = req_tlast;
   end

   // Signed-magnitude add.
   always_comb begin
      logic [19:0] am, bm;
      am = {1'b0, s1_ff.a_mag};
      bm = {1'b0, s1_ff.b_mag};
      s2_in.last = s1_ff.last;
      if (s1_ff.a_sign == s1_ff.b_sign) begin
         s2_in.sign = s1_ff.a_sign;
         s2_in.mag  = am + bm;
      end else if (am >= bm) begin
         s2_in.sign = s1_ff.a_sign;
         s2_in.mag  = am - bm;
      end else begin
         s2_in.sign = s1_ff.b_sign;
         s2_in.mag  = bm - am;
      end
   end

   // Leading-one position of the magnitude.
   always_comb begin
      s3_in.sign = s2_ff.sign;
      s3_in.mag  = s2_ff.mag;
      s3_in.last = s2_ff.last;
      s3_in.pos  = 5'd0;
      for (int i = 0; i < SumWidth; i++) begin
         if (s2_ff.mag[i]) s3_in.pos = 5'(i);
      end
   end

   // Encode: clamp the exponent, take three truncated fraction bits.
   always_comb begin
      logic [19:0] norm;
      logic [3:0]  ex;
      norm = s3_ff.mag << (5'd19 - s3_ff.pos);
      if (s3_ff.pos < 5'd3)       ex = 4'd0;
      else if (s3_ff.pos > 5'd18) ex = ExpMax;
      else                        ex = 4'(s3_ff.pos - 5'd3);
      if (s3_ff.mag == 20'd0) s4_in = 8'h00;
      else                    s4_in = {s3_ff.sign, ex, norm[18:16]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) begin
         s4_ff <= s4_in;
         l4_ff <= s3_ff.last;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = s4_ff;
   assign rsp_tlast  = l4_ff;

   // A held result keeps its data while the receiver stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // The input side is never ready while a full pipeline is stalled.
   a_full: assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready |-> !req_tready)
      else $error("ready while stalled and full");
   // A zero sum is always encoded as positive zero.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      v3_ff && en4 && s3_ff.mag == 20'd0 |=> rsp_tdata == 8'h00)
      else $error("zero sum not encoded as 0x00");
endmodule

// File: bench/tb_minifloat8_e4m3_adder.sv
// Testbench for the minifloat adder: drives operand pairs, predicts each encoded sum
// and checks every response in order. Depends on the minifloat8_e4m3_adder RTL.
`timescale 1ns / 1ps
module tb_minifloat8_e4m3_adder;

   // Expected response of one operand pair.
   typedef struct packed {
      logic [7:0] sum_code;
      logic       last;
   } sum_exp_type;

   // Keeps the pending sums and counts mismatches.
   class sum_scoreboard;
      sum_exp_type pending[$];
      int          mismatches;

      // Signed magnitude of a code in units of 2^-10.
      function automatic longint decode_mag(logic [7:0] code);
         longint mag;
         if (code[6:0] == 7'd0) return 0;
         mag = longint'({1'b1, code[2:0]}) <<< code[6:3];
         return code[7] ? -mag : mag;
      endfunction

      // Encodes an exact sum, truncating and clamping the exponent.
      function automatic logic [7:0] encode_sum(longint total);
         longint     mag;
         int         pos;
         int         biased;
         logic [2:0] frac;
         if (total == 0) return 8'h00;
         mag = (total < 0) ? -total : total;
         pos = 0;
         while (pos < 62 && (mag >>> (pos + 1)) != 0) pos++;
         biased = pos - 3;
         if (biased < 0) biased = 0;
         if (biased > 15) biased = 15;
         if (pos >= 3) frac = 3'((mag >>> (pos - 3)) & 7);
         else frac = 3'((mag <<< (3 - pos)) & 7);
         return {total < 0, 4'(biased), frac};
      endfunction

      function void note_request(logic [7:0] a, logic [7:0] b, logic last);
         sum_exp_type e;
         e.sum_code = encode_sum(decode_mag(a) + decode_mag(b));
         e.last = last;
         pending.push_back(e);
      endfunction

      function void check_response(logic [7:0] code, logic last);
         sum_exp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response code=%h last=%b", code, last);
            return;
         end
         e = pending.pop_front();
         if (e.sum_code !== code || e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected code=%h last=%b, got code=%h last=%b",
                        e.sum_code, e.last, code, last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // a_code [7:0], b_code [15:8]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // sum_code [7:0]
   logic        rsp_tlast;

   sum_scoreboard sb = new();
   bit  stim_done = 1'b0;
   int  cycle_count = 0;
   int  hold_off = 0;
   localparam int CycleLimit = 200000;

   minifloat8_e4m3_adder u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tdata[7:0], req_tdata[15:8], req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tlast);
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver stall pattern with one long hold-off early in the random part.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (cycle_count == 200) begin
         hold_off <= 60;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (cycle_count % 300 < 100) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // Offers one transaction and waits for its acceptance.
   task automatic send_pair(logic [7:0] a, logic [7:0] b, logic last);
      req_tvalid <= 1'b1;
      req_tdata <= {b, a};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Gap between bursts, lowering valid only when a gap really falls.
   task automatic maybe_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [7:0] rand_code();
      case ($urandom_range(0, 5))
         0: return {1'($urandom), 7'd0};
         1: return {1'($urandom), 4'hF, 3'($urandom)};
         2: return {1'($urandom), 4'h0, 3'($urandom)};
         default: return 8'($urandom);
      endcase
   endfunction

   logic [7:0] directed_a[20] = '{8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h7F, 8'h01, 8'h81,
      8'h38, 8'hB8, 8'h40, 8'h08, 8'h78, 8'h3F, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hF8};
   logic [7:0] directed_b[20] = '{8'h00, 8'h80, 8'h80, 8'h7F, 8'hFF, 8'hFF, 8'h81, 8'h01,
      8'hB8, 8'h38, 8'hC0, 8'h88, 8'h78, 8'h3F, 8'h00, 8'h7F, 8'h01, 8'hAA, 8'h55, 8'hF8};

   initial begin
      int burst;
      int n;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Directed part: zeros of both signs, cancellation, clamped exponents.
      for (int i = 0; i < 20; i++) send_pair(directed_a[i], directed_b[i], i[0]);
      // Random bursts.
      n = 0;
      while (n < 1150) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst; k++) begin
            send_pair(rand_code(), rand_code(), 1'($urandom));
            n++;
         end
         maybe_gap();
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // End of run once every response has arrived.
   initial begin
      wait (stim_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
